/* hw/rtl/sbi_pkg.sv */
// ----------------------------------------------------------------------------
// sbi_pkg: shared types and constants of the soft break inserter
// Word formats of both channels, markup characters and the break tag.
// ----------------------------------------------------------------------------
package sbi_pkg;

  // input word: one byte of markup text
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_word_t;

  // output word: a tag byte or the passed-through text byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       text_done;
  } out_word_t;

  // register reset and counter ceiling
  localparam logic [7:0] LIMIT_RESET = 8'd40;
  localparam logic [7:0] COUNT_MAX   = 8'd255;

  // markup characters
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // escape progress codes
  localparam logic [2:0] ESC_NONE   = 3'd0;
  localparam logic [2:0] ESC_AMP    = 3'd1;
  localparam logic [2:0] ESC_HASH   = 3'd2;
  localparam logic [2:0] ESC_DIG2   = 3'd4;
  localparam logic [2:0] ESC_DIG3   = 3'd5;

  // output phases: tag bytes 0..4, then the text byte itself
  localparam logic [2:0] PHASE_TAG0 = 3'd0;
  localparam logic [2:0] PHASE_BYTE = 3'd5;

  // bytes of the break tag <wbr>
  function automatic logic [7:0] wbr_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h3C;
      3'd1:    b = 8'h77;
      3'd2:    b = 8'h62;
      3'd3:    b = 8'h72;
      3'd4:    b = 8'h3E;
      default: b = 8'h3E;
    endcase
    return b;
  endfunction

endpackage

/* hw/rtl/soft_break_inserter.sv */
// ----------------------------------------------------------------------------
// soft_break_inserter: soft line-break insertion for markup text
// Counts visible characters outside tags and inserts <wbr> before the byte
// at which the run reaches the configured limit.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            word
//  in        input      in_valid / in_stall  sbi_pkg::in_word_t
//  out       output     out_valid / out_stall sbi_pkg::out_word_t
//  cfg       input      cfg_valid / cfg_ready break_limit, 8 bits
//
// one text byte per cycle when no break is inserted and out_stall is low; a
// byte that triggers a break is sent as five tag bytes plus itself, paced by the
// output register. a one-word skid buffer holds an input byte while the
// output register is busy, so in_stall is a register output.
// rst is synchronous; it sets break_limit to 40 and clears the text state.
// out_stall holds the output word; no word is lost or repeated.
//
module soft_break_inserter (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sbi_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output sbi_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_break_limit
);

  // configuration and text state
  logic [7:0] break_limit;
  logic       outside_tag, outside_tag_next;
  logic [7:0] run_count, run_count_next;
  logic [2:0] escape_progress, escape_progress_next;

  // skid buffer
  logic              skid_full;
  sbi_pkg::in_word_t skid_word;

  // output register
  logic       busy;
  logic [2:0] phase;
  logic [7:0] hold_byte;
  logic       hold_eot;

  // datapath control
  sbi_pkg::in_word_t src_word;
  logic       src_valid;
  logic       take;
  logic       in_accept;
  logic       insert;
  logic       terminated;
  logic       is_digit;
  logic [7:0] c;
  logic [8:0] sum;
  logic [7:0] sum_sat;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_full;
  assign in_accept = in_valid && !skid_full;

  // source of the next byte: skid buffer first
  assign src_word  = skid_full ? skid_word : in_word;
  assign src_valid = skid_full || in_valid;
  assign take      = src_valid &&
                     (!busy || (!out_stall && phase == sbi_pkg::PHASE_BYTE));

  // scan logic for one byte
  always_comb begin
    c        = src_word.in_byte;
    is_digit = (c >= sbi_pkg::CH_ZERO) && (c <= sbi_pkg::CH_NINE);
    outside_tag_next     = outside_tag;
    run_count_next       = run_count;
    escape_progress_next = escape_progress;
    insert     = 1'b0;
    terminated = 1'b0;
    sum        = 9'd0;
    sum_sat    = 8'd0;
    if (c == sbi_pkg::CH_LT) begin
      outside_tag_next = 1'b0;
    end else if (c == sbi_pkg::CH_GT) begin
      outside_tag_next = 1'b1;
    end else if (outside_tag && c == sbi_pkg::CH_SPACE) begin
      run_count_next = 8'd0;
    end else if (outside_tag) begin
      if (c == sbi_pkg::CH_AMP && escape_progress == sbi_pkg::ESC_NONE) begin
        escape_progress_next = sbi_pkg::ESC_AMP;
      end else if (c == sbi_pkg::CH_HASH && escape_progress == sbi_pkg::ESC_AMP) begin
        escape_progress_next = sbi_pkg::ESC_HASH;
      end else if (is_digit && escape_progress >= sbi_pkg::ESC_HASH &&
                   escape_progress <= sbi_pkg::ESC_DIG2) begin
        escape_progress_next = escape_progress + 3'd1;
      end else if (c == sbi_pkg::CH_SEMI && (escape_progress == sbi_pkg::ESC_DIG2 ||
                                             escape_progress == sbi_pkg::ESC_DIG3)) begin
        // finished escape counts as one character
        sum        = {1'b0, run_count} + 9'd1;
        sum_sat    = sum[8] ? sbi_pkg::COUNT_MAX : sum[7:0];
        run_count_next       = sum_sat;
        escape_progress_next = sbi_pkg::ESC_NONE;
        terminated = 1'b1;
      end else begin
        // plain byte, or a broken escape adding back its bytes
        sum     = {1'b0, run_count} + 9'd1 + {6'd0, escape_progress};
        sum_sat = sum[8] ? sbi_pkg::COUNT_MAX : sum[7:0];
        run_count_next       = sum_sat;
        escape_progress_next = sbi_pkg::ESC_NONE;
      end
      if (!terminated && run_count_next >= break_limit &&
          escape_progress_next <= sbi_pkg::ESC_AMP) begin
        insert         = 1'b1;
        run_count_next = 8'd0;
      end
    end
    // end of text restores the scan state
    if (src_word.end_of_text) begin
      outside_tag_next     = 1'b1;
      run_count_next       = 8'd0;
      escape_progress_next = sbi_pkg::ESC_NONE;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      break_limit <= sbi_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      break_limit <= cfg_break_limit;
    end
  end

  // text state
  always_ff @(posedge clk) begin
    if (rst) begin
      outside_tag     <= 1'b1;
      run_count       <= 8'd0;
      escape_progress <= sbi_pkg::ESC_NONE;
    end else if (take) begin
      outside_tag     <= outside_tag_next;
      run_count       <= run_count_next;
      escape_progress <= escape_progress_next;
    end
  end

  // skid buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (take) begin
        skid_full <= 1'b0;
      end
    end else if (in_accept && !take) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full && in_accept) begin
      skid_word <= in_word;
    end
  end

  // output sequencer: tag bytes then the text byte
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= sbi_pkg::PHASE_BYTE;
    end else if (take) begin
      busy  <= 1'b1;
      phase <= insert ? sbi_pkg::PHASE_TAG0 : sbi_pkg::PHASE_BYTE;
    end else if (busy && !out_stall) begin
      if (phase == sbi_pkg::PHASE_BYTE) begin
        busy <= 1'b0;
      end else begin
        phase <= phase + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_byte <= src_word.in_byte;
      hold_eot  <= src_word.end_of_text;
    end
  end

  // output word
  assign out_valid = busy;
  always_comb begin
    if (phase == sbi_pkg::PHASE_BYTE) begin
      out_word.out_byte    = hold_byte;
      out_word.last_of_run = 1'b1;
      out_word.text_done   = hold_eot;
    end else begin
      out_word.out_byte    = sbi_pkg::wbr_byte(phase);
      out_word.last_of_run = 1'b0;
      out_word.text_done   = 1'b0;
    end
  end

  // a word accepted while the output is busy lands in the skid buffer
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !take) |=> skid_full)
    else $error("accepted word not held in skid buffer");

  // tag bytes advance one phase per delivered word
  a_phase_step: assert property (@(posedge clk) disable iff (rst)
    (busy && !out_stall && phase != sbi_pkg::PHASE_BYTE && !take)
      |=> (busy && phase == $past(phase) + 3'd1))
    else $error("tag sequence skipped or repeated a byte");

  // escape progress stays within its codes
  a_esc_range: assert property (@(posedge clk) disable iff (rst)
    escape_progress <= sbi_pkg::ESC_DIG3)
    else $error("escape progress out of range");

endmodule
